### design/c3zp_pkg.sv
// c3zp_pkg: shared widths, types and register codes for the 3x3 streaming convolver.
// No dependencies; imported by conv3x3_zero_pad_stream.
package c3zp_pkg;

    localparam int PIX_W       = 16;   // input sample
    localparam int COEF_W      = 16;   // Q4.12 coefficient
    localparam int FRAC_BITS   = 12;
    localparam int OUT_W       = 24;   // saturated result
    localparam int COL_OUT_W   = 10;
    localparam int ROW_W       = 16;
    localparam int ROW_CNT_W   = 17;   // input row counter
    localparam int EMIT_W      = 27;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_W    = 16;
    localparam int KROW_W      = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int KSIZE       = 3;
    localparam int TAPS        = KSIZE * KSIZE;
    localparam int PROD_W      = 32;   // 16x16 signed product
    localparam int PART_W      = 33;   // sum of one window row
    localparam int SUM_W       = 35;   // sum of all nine taps

    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;
    typedef logic signed [PIX_W-1:0]   t_pix;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [PART_W-1:0]  t_part;
    typedef logic signed [SUM_W-1:0]   t_sum;

    // configuration register indexes
    localparam t_cfg_idx CFG_IMAGE_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_KROW_TOP     = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_KROW_MIDDLE  = t_cfg_idx'(3);
    localparam t_cfg_idx CFG_KROW_BOTTOM  = t_cfg_idx'(4);

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = WIDTH_REG_W'(1024);
    localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = HEIGHT_W'(1);

    localparam t_sum SAT_MAX = t_sum'((1 <<< (OUT_W - 1)) - 1);
    localparam t_sum SAT_MIN = t_sum'(-(1 <<< (OUT_W - 1)));

    // which window borders fall outside the image for one output pixel
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edge_mask;

endpackage

### design/conv3x3_zero_pad_stream.sv
// conv3x3_zero_pad_stream: streaming 3x3 convolution with zero padding, top level.
// Holds the line store, the 3x3 window, the frame counters and a four-stage datapath.
// Depends on c3zp_pkg.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_stall      | i_op, i_pixel_value
//  output   | o_out_valid / i_out_stall    | o_conv_value, o_out_col, o_out_row,
//           |                              | o_frame_last
//  config   | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One input transaction per cycle, sustained while the output is not stalled. A result
// is valid at the output once it has passed the registers window, products, row sums
// and final sum with shift and saturation.
// i_rst_n is synchronous and active low; it clears counters, window and valid flags.
// The line store is not cleared: entries not yet written only feed border taps.
// An output stall backs up through the stages; o_in_stall rises only when stage one
// is full and cannot move.
module conv3x3_zero_pad_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_op,
    input  logic signed [c3zp_pkg::PIX_W-1:0]    i_pixel_value,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [c3zp_pkg::OUT_W-1:0]    o_conv_value,
    output logic [c3zp_pkg::COL_OUT_W-1:0]       o_out_col,
    output logic [c3zp_pkg::ROW_W-1:0]           o_out_row,
    output logic                                 o_frame_last,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [c3zp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [c3zp_pkg::KROW_W-1:0]          i_cfg_data
);
    import c3zp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);          // column / line store address
    localparam int WW = $clog2(MAX_WIDTH + 1);      // effective width 1..MAX_WIDTH
    localparam int EW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
    localparam int AREA_W = WW + HEIGHT_W;

    // effective width: zero counts as one, clamp to the line store size
    function automatic logic [WW-1:0] f_eff_w(input logic [WIDTH_REG_W-1:0] w);
        logic [EW-1:0] we;
        begin
            we = EW'(w);
            if (we == '0) begin
                return WW'(1);
            end else if (we > EW'(MAX_WIDTH)) begin
                return WW'(MAX_WIDTH);
            end
            return WW'(we);
        end
    endfunction

    function automatic logic [HEIGHT_W-1:0] f_eff_h(input logic [HEIGHT_W-1:0] h);
        return (h == '0) ? HEIGHT_W'(1) : h;
    endfunction

    //------------------------------------------------------------------
    // configuration registers
    //------------------------------------------------------------------
    logic [WIDTH_REG_W-1:0] r_width,  n_width;
    logic [HEIGHT_W-1:0]    r_height, n_height;
    logic [KROW_W-1:0]      r_krow [KSIZE];
    logic [KROW_W-1:0]      n_krow [KSIZE];
    logic [EMIT_W-1:0]      r_total, n_total;     // pixels per frame
    logic [AREA_W-1:0]      n_area;
    logic                   cfg_wr;
    logic                   geom_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_krow   = r_krow;
        geom_wr  = 1'b0;
        if (cfg_wr) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    n_width = i_cfg_data[WIDTH_REG_W-1:0];
                    geom_wr = 1'b1;
                end
                CFG_IMAGE_HEIGHT: begin
                    n_height = i_cfg_data[HEIGHT_W-1:0];
                    geom_wr  = 1'b1;
                end
                CFG_KROW_TOP:    n_krow[0] = i_cfg_data;
                CFG_KROW_MIDDLE: n_krow[1] = i_cfg_data;
                CFG_KROW_BOTTOM: n_krow[2] = i_cfg_data;
                default: ;
            endcase
        end
        n_area  = f_eff_w(n_width) * f_eff_h(n_height);
        n_total = EMIT_W'(n_area);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_krow   <= '{default: '0};
            r_total  <= EMIT_W'(f_eff_w(WIDTH_RESET));
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_krow   <= n_krow;
            r_total  <= n_total;
        end
    end

    //------------------------------------------------------------------
    // pipeline flow control: each stage moves when the next has room
    //------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic in_acc;

    assign rdy4       = !r_v4 || !i_out_stall;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_in_stall = !rdy1;
    assign in_acc     = i_in_valid && rdy1;

    //------------------------------------------------------------------
    // frame position, output position and border flags
    //------------------------------------------------------------------
    logic [CW-1:0]        r_col, n_col;
    logic [ROW_CNT_W-1:0] r_row, n_row;
    logic [EMIT_W-1:0]    r_emit, n_emit;

    logic [WW-1:0]        w_eff;
    logic [HEIGHT_W-1:0]  h_eff;
    logic [WW-1:0]        col_inc;
    logic                 col_wrap;
    logic                 emit_now;
    logic                 item_last;
    logic [CW-1:0]        ox;
    logic [ROW_CNT_W-1:0] oy;
    t_edge_mask           edge_now;
    t_pix                 pix_in;

    always_comb begin
        w_eff    = f_eff_w(r_width);
        h_eff    = f_eff_h(r_height);
        col_inc  = WW'(r_col) + WW'(1);
        col_wrap = (col_inc >= w_eff);
        emit_now = (r_row >= ROW_CNT_W'(2)) || (r_row == ROW_CNT_W'(1) && r_col != '0);
        // output pixel sits one row and one column behind the input position
        if (r_col != '0) begin
            ox = r_col - CW'(1);
            oy = r_row - ROW_CNT_W'(1);
        end else begin
            ox = CW'(w_eff - WW'(1));
            oy = r_row - ROW_CNT_W'(2);
        end
        edge_now.top    = (oy == '0);
        edge_now.bottom = (oy == ROW_CNT_W'(h_eff) - ROW_CNT_W'(1));
        edge_now.left   = (ox == '0);
        edge_now.right  = (ox == CW'(w_eff - WW'(1)));
        item_last = emit_now && ((r_emit + EMIT_W'(1)) == r_total);
        pix_in    = i_op ? '0 : i_pixel_value;

        n_col  = r_col;
        n_row  = r_row;
        n_emit = r_emit;
        if (geom_wr) begin
            n_col  = '0;
            n_row  = '0;
            n_emit = '0;
        end else if (in_acc) begin
            if (item_last) begin
                n_col  = '0;
                n_row  = '0;
                n_emit = '0;
            end else begin
                if (emit_now) begin
                    n_emit = r_emit + EMIT_W'(1);
                end
                if (col_wrap) begin
                    n_col = '0;
                    n_row = r_row + ROW_CNT_W'(1);
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_emit <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_emit <= n_emit;
        end
    end

    //------------------------------------------------------------------
    // line store: two rows, read ahead at the next column, write-through
    // bypass when the next column equals the one written (width of
    // one, only on an accepted transaction)
    //------------------------------------------------------------------
    t_pix r_line_top [MAX_WIDTH];
    t_pix r_line_mid [MAX_WIDTH];
    t_pix r_top_q, r_mid_q;
    t_pix r_byp_top, r_byp_mid;
    logic r_byp;
    t_pix top_rd, mid_rd;

    assign top_rd = r_byp ? r_byp_top : r_top_q;
    assign mid_rd = r_byp ? r_byp_mid : r_mid_q;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_line_top[r_col] <= mid_rd;
            r_line_mid[r_col] <= pix_in;
        end
        r_top_q   <= r_line_top[n_col];
        r_mid_q   <= r_line_mid[n_col];
        r_byp_top <= mid_rd;
        r_byp_mid <= pix_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= in_acc && (n_col == r_col);
        end
    end

    //------------------------------------------------------------------
    // stage 1: window shift and output tag on every transaction; valid when due
    //------------------------------------------------------------------
    t_pix                 r_win [TAPS];
    t_edge_mask           r_s1_edge;
    logic [COL_OUT_W-1:0] r_s1_col;
    logic [ROW_W-1:0]     r_s1_row;
    logic                 r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_win <= '{default: '0};
        end else begin
            if (in_acc) begin
                for (int wr = 0; wr < KSIZE; wr++) begin
                    r_win[wr*KSIZE + 0] <= r_win[wr*KSIZE + 1];
                    r_win[wr*KSIZE + 1] <= r_win[wr*KSIZE + 2];
                end
                r_win[2] <= top_rd;
                r_win[5] <= mid_rd;
                r_win[8] <= pix_in;
                r_v1     <= emit_now;
            end else if (rdy2) begin
                r_v1 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_edge <= edge_now;
            r_s1_col  <= COL_OUT_W'(ox);
            r_s1_row  <= oy[ROW_W-1:0];
            r_s1_last <= item_last;
        end
    end

    //------------------------------------------------------------------
    // stage 2: nine products, border taps forced to zero
    //------------------------------------------------------------------
    t_prod                r_prod [TAPS];
    t_prod                n_prod [TAPS];
    logic [COL_OUT_W-1:0] r_s2_col;
    logic [ROW_W-1:0]     r_s2_row;
    logic                 r_s2_last;

    always_comb begin
        t_coef coef;
        t_pix  tap;
        logic  off;
        for (int wr = 0; wr < KSIZE; wr++) begin
            for (int wc = 0; wc < KSIZE; wc++) begin
                off = (wr == 0 && r_s1_edge.top)  || (wr == KSIZE-1 && r_s1_edge.bottom) ||
                      (wc == 0 && r_s1_edge.left) || (wc == KSIZE-1 && r_s1_edge.right);
                tap  = off ? '0 : r_win[wr*KSIZE + wc];
                // true convolution: kernel flipped in both directions
                coef = t_coef'(r_krow[KSIZE-1-wr][COEF_W*(KSIZE-1-wc) +: COEF_W]);
                n_prod[wr*KSIZE + wc] = coef * tap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_prod    <= n_prod;
            r_s2_col  <= r_s1_col;
            r_s2_row  <= r_s1_row;
            r_s2_last <= r_s1_last;
        end
    end

    //------------------------------------------------------------------
    // stage 3: per-row partial sums
    //------------------------------------------------------------------
    t_part                r_part [KSIZE];
    t_part                n_part [KSIZE];
    logic [COL_OUT_W-1:0] r_s3_col;
    logic [ROW_W-1:0]     r_s3_row;
    logic                 r_s3_last;

    always_comb begin
        for (int g = 0; g < KSIZE; g++) begin
            n_part[g] = PART_W'(r_prod[g*KSIZE + 0]) + PART_W'(r_prod[g*KSIZE + 1]) +
                        PART_W'(r_prod[g*KSIZE + 2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_part    <= n_part;
            r_s3_col  <= r_s2_col;
            r_s3_row  <= r_s2_row;
            r_s3_last <= r_s2_last;
        end
    end

    //------------------------------------------------------------------
    // stage 4: total, floor shift, saturation into the output register
    //------------------------------------------------------------------
    t_sum                     sum_all;
    t_sum                     sum_shr;
    logic signed [OUT_W-1:0]  n_conv;
    logic signed [OUT_W-1:0]  r_conv;
    logic [COL_OUT_W-1:0]     r_ocol;
    logic [ROW_W-1:0]         r_orow;
    logic                     r_olast;

    always_comb begin
        sum_all = SUM_W'(r_part[0]) + SUM_W'(r_part[1]) + SUM_W'(r_part[2]);
        sum_shr = sum_all >>> FRAC_BITS;
        if (sum_shr > SAT_MAX) begin
            n_conv = OUT_W'(SAT_MAX);
        end else if (sum_shr < SAT_MIN) begin
            n_conv = OUT_W'(SAT_MIN);
        end else begin
            n_conv = OUT_W'(sum_shr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            r_conv  <= n_conv;
            r_ocol  <= r_s3_col;
            r_orow  <= r_s3_row;
            r_olast <= r_s3_last;
        end
    end

    assign o_out_valid  = r_v4;
    assign o_conv_value = r_conv;
    assign o_out_col    = r_ocol;
    assign o_out_row    = r_orow;
    assign o_frame_last = r_olast;

    //------------------------------------------------------------------
    // checks
    //------------------------------------------------------------------
    // output count stays inside the frame
    a_emit_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit < r_total)
        else $error("emit count reached frame size");

    // an accepted transaction fills stage one exactly when it produces a result
    a_stage1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_v1 == $past(emit_now)))
        else $error("stage one valid does not match output due");

    // the final output of a frame restarts the position counters
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && item_last) |=> (r_col == '0 && r_row == '0 && r_emit == '0))
        else $error("frame did not restart after last output");

endmodule

### test/conv3x3_zero_pad_stream_tb.sv
// conv3x3_zero_pad_stream_tb: self-checking bench for the streaming 3x3 zero-padded convolver.
// Holds a bit-exact convolution scoreboard and randomized stream/stall drivers.
// Depends on c3zp_pkg and conv3x3_zero_pad_stream.
module conv3x3_zero_pad_stream_tb;
    import c3zp_pkg::*;

    localparam int      MAX_W           = 1024;
    localparam int      CLK_PERIOD      = 10;
    localparam int      RANDOM_ITEMS    = 250;
    localparam int      WIDE_TAIL       = 32;      // items past the first row of the wide frame
    localparam int      DRAIN_CYCLES    = 12;      // four-stage pipe plus a stalled receiver
    localparam int      PRESSURE_AT     = 60;      // result count that triggers the long hold
    localparam int      PRESSURE_CYCLES = 200;
    localparam longint  RUN_LIMIT       = 4_000_000;

    // input transaction kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic [COL_OUT_W-1:0]    col;
        logic [ROW_W-1:0]        row;
        logic                    last;
    } t_conv_result;

    // Scoreboard: mirrors the line store, the window and the frame counters, and
    // queues one expected output pixel for every input transaction that yields one.
    class conv3x3_scoreboard;
        logic [WIDTH_REG_W-1:0] width_reg;
        logic [HEIGHT_W-1:0]    height_reg;
        logic [KROW_W-1:0]      krow [KSIZE];
        t_pix                   line_mem [2*MAX_W];
        t_pix                   win_regs [TAPS];
        int unsigned            in_col;
        logic [ROW_CNT_W-1:0]   in_row;
        logic [EMIT_W-1:0]      emit_count;
        t_conv_result           expected_pixels [$];
        int                     errors;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (krow[i]) krow[i] = '0;
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (win_regs[i]) win_regs[i] = '0;
            restart_frame();
            errors = 0;
        endfunction

        function void restart_frame();
            in_col     = 0;
            in_row     = '0;
            emit_count = '0;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void apply_config(t_cfg_idx idx, logic [KROW_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH: begin
                    width_reg = data[WIDTH_REG_W-1:0];
                    restart_frame();
                end
                CFG_IMAGE_HEIGHT: begin
                    height_reg = data[HEIGHT_W-1:0];
                    restart_frame();
                end
                CFG_KROW_TOP:    krow[0] = data;
                CFG_KROW_MIDDLE: krow[1] = data;
                CFG_KROW_BOTTOM: krow[2] = data;
                default: ;
            endcase
        endfunction

        // One accepted input transaction: shift the window, update the line store,
        // and when an output is due, form the masked, floored and saturated sum.
        function void accept_pixel(logic op, t_pix pix);
            int unsigned  w, h, c, r, ox, oy;
            int           wr, wc;
            t_pix         sample, above2, above1;
            t_coef        k;
            longint       acc, q;
            bit           skip, last;
            t_conv_result res;

            w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
            h = (height_reg == 0) ? 1 : height_reg;
            c = (in_col >= w) ? 0 : in_col;
            r = in_row;
            sample = (op == OP_FLUSH) ? t_pix'(0) : pix;

            above2 = line_mem[c];
            above1 = line_mem[MAX_W + c];
            line_mem[c]         = above1;
            line_mem[MAX_W + c] = sample;

            for (wr = 0; wr < KSIZE; wr++) begin
                win_regs[wr*3]     = win_regs[wr*3 + 1];
                win_regs[wr*3 + 1] = win_regs[wr*3 + 2];
            end
            win_regs[2] = above2;
            win_regs[5] = above1;
            win_regs[8] = sample;

            last = 1'b0;
            if (r >= 2 || (r == 1 && c >= 1)) begin
                if (c >= 1) begin
                    ox = c - 1;
                    oy = r - 1;
                end else begin
                    ox = w - 1;
                    oy = r - 2;
                end
                acc = 0;
                for (wr = 0; wr < KSIZE; wr++) begin
                    for (wc = 0; wc < KSIZE; wc++) begin
                        // taps beyond the image border read as zero
                        skip = (wr == 0 && oy == 0) || (wr == 2 && oy == h - 1) ||
                               (wc == 0 && ox == 0) || (wc == 2 && ox == w - 1);
                        if (!skip) begin
                            // flipped kernel: window tap (wr,wc) meets K[2-wr][2-wc]
                            k = krow[2 - wr][16*(2 - wc) +: 16];
                            acc += longint'(k) * longint'(win_regs[wr*3 + wc]);
                        end
                    end
                end
                q = acc >>> FRAC_BITS;
                if (q > longint'(SAT_MAX)) q = longint'(SAT_MAX);
                if (q < longint'(SAT_MIN)) q = longint'(SAT_MIN);
                last = ((longint'(emit_count) + 1) == longint'(w) * longint'(h));
                res.value = OUT_W'(q);
                res.col   = COL_OUT_W'(ox);
                res.row   = ROW_W'(oy);
                res.last  = last;
                expected_pixels.push_back(res);
                emit_count = emit_count + 1'b1;
            end

            if (last) begin
                restart_frame();
            end else if (c + 1 >= w) begin
                in_col = 0;
                in_row = ROW_CNT_W'(r + 1);
            end else begin
                in_col = c + 1;
            end
        endfunction

        function void check_conv_output(logic signed [OUT_W-1:0] value,
                                        logic [COL_OUT_W-1:0] col,
                                        logic [ROW_W-1:0] row, logic last);
            t_conv_result want;
            if (expected_pixels.size() == 0) begin
                $error("unexpected output pixel at col %0d row %0d", col, row);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (value !== want.value) begin
                $error("conv_value: expected %0d, got %0d", want.value, value);
                errors++;
            end
            if (col !== want.col) begin
                $error("out_col: expected %0d, got %0d", want.col, col);
                errors++;
            end
            if (row !== want.row) begin
                $error("out_row: expected %0d, got %0d", want.row, row);
                errors++;
            end
            if (last !== want.last) begin
                $error("frame_last: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_op;
    logic signed [PIX_W-1:0] i_pixel_value;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [OUT_W-1:0] o_conv_value;
    logic [COL_OUT_W-1:0]    o_out_col;
    logic [ROW_W-1:0]        o_out_row;
    logic                    o_frame_last;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [KROW_W-1:0]       i_cfg_data;

    conv3x3_scoreboard sb = new();

    // quiet stretches: when set, that side neither idles nor stalls
    bit in_quiet  = 1'b0;
    bit out_quiet = 1'b0;
    int items_sent = 0;

    t_cfg_idx krow_idx [KSIZE] = '{CFG_KROW_TOP, CFG_KROW_MIDDLE, CFG_KROW_BOTTOM};

    conv3x3_zero_pad_stream #(.MAX_WIDTH(MAX_W)) dut (.*);

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // Biased sample source: full-scale extremes show up often.
    function automatic t_pix pick_pixel();
        case ($urandom_range(0, 7))
            0:       return t_pix'(32767);
            1:       return t_pix'(-32768);
            default: return t_pix'($urandom);
        endcase
    endfunction

    // Inputs change on the falling edge; handshakes are judged on the rising edge.
    task automatic push_item(logic op, t_pix pix);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_op          = op;
        i_pixel_value = pix;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.accept_pixel(op, pix);
        @(negedge i_clk);
        items_sent++;
        if (items_sent % 40 == 0) in_quiet = ($urandom_range(0, 2) == 0);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [KROW_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.apply_config(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Let every expected pixel come out, then give transactions that carry no
    // result time to leave the pipe before registers change.
    task automatic drain_block();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_geometry(int w, int h);
        logic [KROW_W-1:0] wd, hd;
        wd = KROW_W'({$urandom, $urandom});
        hd = KROW_W'({$urandom, $urandom});
        wd[WIDTH_REG_W-1:0] = WIDTH_REG_W'(w);
        hd[HEIGHT_W-1:0]    = HEIGHT_W'(h);
        if ($urandom_range(0, 1)) begin
            cfg_write(CFG_IMAGE_WIDTH, wd);
            cfg_write(CFG_IMAGE_HEIGHT, hd);
        end else begin
            cfg_write(CFG_IMAGE_HEIGHT, hd);
            cfg_write(CFG_IMAGE_WIDTH, wd);
        end
    endtask

    // Result sink: random stalls per transaction, one long hold to back the pipe up.
    initial begin : result_sink
        int hold;
        int taken;
        i_out_stall = 1'b0;
        taken = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (taken == PRESSURE_AT) hold = PRESSURE_CYCLES;
            else hold = out_quiet ? 0 : $urandom_range(0, 4);
            if (hold > 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_conv_output(o_conv_value, o_out_col, o_out_row, o_frame_last);
            taken++;
            if (taken % 40 == 0) out_quiet = ($urandom_range(0, 2) == 0);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int w, h, nframes, flen, mode, n, f, rand_items;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = OP_PIXEL;
        i_pixel_value = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_IMAGE_WIDTH;
        i_cfg_data    = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed: 3x2 frame, extreme samples and coefficients, flushes carry junk
        cfg_write(CFG_IMAGE_WIDTH, KROW_W'(3));
        cfg_write(CFG_IMAGE_HEIGHT, KROW_W'(2));
        cfg_write(CFG_KROW_TOP,    {16'h1000, 16'h8000, 16'h7FFF});
        cfg_write(CFG_KROW_MIDDLE, {16'hFFFF, 16'h0001, 16'hF000});
        cfg_write(CFG_KROW_BOTTOM, {16'h8000, 16'h7FFF, 16'h0800});
        push_item(OP_PIXEL, t_pix'(32767));
        push_item(OP_PIXEL, t_pix'(-32768));
        push_item(OP_PIXEL, t_pix'(-1));
        push_item(OP_PIXEL, t_pix'(1));
        push_item(OP_PIXEL, t_pix'(-32768));
        push_item(OP_PIXEL, t_pix'(32767));
        push_item(OP_FLUSH, t_pix'(-32768));
        push_item(OP_FLUSH, t_pix'(32767));
        push_item(OP_FLUSH, t_pix'(-1));
        push_item(OP_FLUSH, t_pix'(12345));
        drain_block();

        // zero width and zero height both count as one: 1x1 frames back to back,
        // the second with a flush as its pixel and a real pixel in a flush slot
        cfg_write(CFG_IMAGE_WIDTH, KROW_W'(0));
        cfg_write(CFG_IMAGE_HEIGHT, KROW_W'(0));
        push_item(OP_PIXEL, t_pix'(-32768));
        push_item(OP_FLUSH, t_pix'(-1));
        push_item(OP_FLUSH, t_pix'(32767));
        push_item(OP_FLUSH, t_pix'(32767));
        push_item(OP_FLUSH, t_pix'(-32768));
        push_item(OP_PIXEL, t_pix'(-32768));
        drain_block();

        // kernel change in the middle of a 2x2 frame applies from the next output
        cfg_write(CFG_IMAGE_WIDTH, KROW_W'(2));
        cfg_write(CFG_IMAGE_HEIGHT, KROW_W'(2));
        push_item(OP_PIXEL, t_pix'(32767));
        push_item(OP_PIXEL, t_pix'(-32768));
        push_item(OP_PIXEL, t_pix'(-32768));
        push_item(OP_PIXEL, t_pix'(32767));
        drain_block();
        cfg_write(CFG_KROW_MIDDLE, {16'h7FFF, 16'h8000, 16'h7FFF});
        push_item(OP_FLUSH, t_pix'(0));
        push_item(OP_FLUSH, t_pix'(0));
        push_item(OP_FLUSH, t_pix'(0));
        drain_block();

        // --- random phases: new geometry and kernels, then a few frames each;
        // mostly well-formed frames, some noise, some cut short
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                w = $urandom_range(13, 64);
                h = $urandom_range(1, 3);
            end else begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 6);
            end
            set_geometry(w, h);
            for (n = 0; n < KSIZE; n++) begin
                if ($urandom_range(0, 1)) cfg_write(krow_idx[n], KROW_W'({$urandom, $urandom}));
            end
            nframes = $urandom_range(1, 3);
            for (f = 0; f < nframes; f++) begin
                flen = w*h + w + 1;
                mode = $urandom_range(0, 9);
                if (mode == 9) flen = $urandom_range(1, w*h + w);
                for (n = 0; n < flen; n++) begin
                    if (mode == 8) push_item(1'($urandom), pick_pixel());
                    else push_item((n >= w*h) ? OP_FLUSH : OP_PIXEL, pick_pixel());
                    rand_items++;
                end
            end
            drain_block();
        end

        // tallest frame, single column: only a partial run, no frame end
        set_geometry(1, 65535);
        cfg_write(CFG_KROW_MIDDLE, KROW_W'({$urandom, $urandom}));
        for (n = 0; n < 40; n++) push_item(OP_PIXEL, pick_pixel());
        drain_block();

        // widest row; widths above the maximum clamp to it. One full row plus a
        // short tail brings out the first outputs of that row, no frame end.
        set_geometry(MAX_W + $urandom_range(0, MAX_W - 1), 1);
        for (n = 0; n < KSIZE; n++) cfg_write(krow_idx[n], KROW_W'({$urandom, $urandom}));
        for (n = 0; n < MAX_W + WIDE_TAIL; n++) begin
            push_item((n >= MAX_W) ? OP_FLUSH : OP_PIXEL, pick_pixel());
        end
        drain_block();

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #RUN_LIMIT;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
